[hdl/bbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

   // field widths of the channels
   localparam int RED_W  = 8;
   localparam int POS_W  = 10;

   // configuration register widths
   localparam int SRC_DIM_W = 13;
   localparam int OUT_DIM_W = 11;
   localparam int BLK_DIM_W = 7;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST    = 13'd640;
   localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST   = 13'd480;
   localparam logic [OUT_DIM_W-1:0] OUT_WIDTH_RST    = 11'd10;
   localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_RST   = 11'd10;
   localparam logic [BLK_DIM_W-1:0] BLOCK_WIDTH_RST  = 7'd64;
   localparam logic [BLK_DIM_W-1:0] BLOCK_HEIGHT_RST = 7'd48;

   // fixed frame limits
   localparam int SRC_HEIGHT_MAX = 4096;
   localparam int SRC_ROW_W      = 12;
   localparam int OUT_HEIGHT_MAX = 1024;
   localparam int BLOCK_ROW_W    = 11;

   // colour threshold 0.78 as an exact ratio
   localparam int FRAC_NUM = 78;
   localparam int FRAC_DEN = 100;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH    = 3'd0,
      REG_SRC_HEIGHT   = 3'd1,
      REG_OUT_WIDTH    = 3'd2,
      REG_OUT_HEIGHT   = 3'd3,
      REG_BLOCK_WIDTH  = 3'd4,
      REG_BLOCK_HEIGHT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0] out_x;
      logic [POS_W-1:0] out_y;
      logic             is_white;
      logic             frame_done;
   } rsp_item_type;

endpackage

`default_nettype wire

[hdl/binary_block_downscale_core.sv]
// a beat closing a block passes the count update stage, then the result queue offers its result
// throughput: one pixel beat per cycle while req_ready is high; the black-count store is read
// every cycle and written for each covered beat, the last write forwarded into the count update
// ready drops only when four results stand queued or in flight toward the queue
// reset: synchronous, active high; registers return to defaults, position is cleared
// and the count store reads as zero at once through per-row valid bits
`timescale 1ns / 1ps
`default_nettype none

module binary_block_downscale_core #(
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_BLOCK     = 64,
   parameter int MAX_SRC_WIDTH = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bbd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bbd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bbd_pkg::RED_W-1:0]        req_red_value,
   // block results
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bbd_pkg::POS_W-1:0]        rsp_out_x,
   output logic [bbd_pkg::POS_W-1:0]        rsp_out_y,
   output logic                             rsp_is_white,
   output logic                             rsp_frame_done
);

   import bbd_pkg::*;

   localparam int SCW       = $clog2(MAX_SRC_WIDTH);
   localparam int SWW       = SCW + 1;
   localparam int BCW       = $clog2(MAX_OUT_WIDTH + 1);
   localparam int CBW       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int BKW       = $clog2(MAX_BLOCK + 1);
   localparam int CNTW      = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int MW        = CNTW + 7;
   localparam int LANE_BITS = ($clog2(MAX_OUT_WIDTH) > 8) ? $clog2(MAX_OUT_WIDTH) - 8 : 0;
   localparam int LANES     = 1 << LANE_BITS;
   localparam int LW        = (LANE_BITS > 0) ? LANE_BITS : 1;
   localparam int ROWS      = (MAX_OUT_WIDTH + LANES - 1) / LANES;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MEM_DEPTH = 1 << ROW_W;

   typedef logic [LANES-1:0][CNTW-1:0] row_word_type;

   // configuration registers
   logic [SRC_DIM_W-1:0] src_width_ff, src_height_ff;
   logic [OUT_DIM_W-1:0] out_width_ff, out_height_ff;
   logic [BLK_DIM_W-1:0] block_width_ff, block_height_ff;
   logic                 csr_write;

   // clamped configuration
   logic [SWW-1:0]       sw_c;
   logic [SRC_DIM_W-1:0] sh_c;
   logic [BCW-1:0]       ow_c;
   logic [OUT_DIM_W-1:0] oh_c;
   logic [BKW-1:0]       bw_c, bh_c;

   // position in the frame
   logic [SCW-1:0]         src_col_ff, src_col_in;
   logic [SRC_ROW_W-1:0]   src_row_ff, src_row_in;
   logic [CBW-1:0]         col_in_block_ff, col_in_block_in;
   logic [BCW-1:0]         block_col_ff, block_col_in;
   logic [CBW-1:0]         row_in_block_ff, row_in_block_in;
   logic [BLOCK_ROW_W-1:0] block_row_ff, block_row_in;

   logic        accept;
   logic        covered, last_col, last_row, emit, frame_last, restart;
   logic [31:0] bc_ext, br_ext;

   // count update stage
   logic                 s1_valid_ff;
   logic                 s1_black_ff, s1_first_ff, s1_emit_ff, s1_covered_ff;
   logic                 s1_restart_ff, s1_fdone_ff;
   logic [BCW-1:0]       s1_bc_ff;
   logic [POS_W-1:0]     s1_x_ff, s1_y_ff;
   logic [CNTW-1:0]      s1_area_ff;

   // black-count store
   row_word_type         count_mem_ff [0:MEM_DEPTH-1];
   row_word_type         mem_rd_ff;
   row_word_type         fwd_data_ff;
   logic [ROW_W-1:0]     fwd_row_ff;
   logic [MEM_DEPTH-1:0] row_valid_ff;
   logic [ROW_W-1:0]     rd_row, s1_row;
   logic [LW-1:0]        s1_lane;
   row_word_type         row_word, wr_word;
   logic                 wr_en;
   logic [CNTW-1:0]      base_cnt, cnt, wht;
   logic                 is_black;

   // result queue
   rsp_item_type          fifo_ff [0:FIFO_DEPTH-1];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, occupancy;
   logic                  push, pop;
   rsp_item_type          push_item, head;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= SRC_WIDTH_RST;
         src_height_ff   <= SRC_HEIGHT_RST;
         out_width_ff    <= OUT_WIDTH_RST;
         out_height_ff   <= OUT_HEIGHT_RST;
         block_width_ff  <= BLOCK_WIDTH_RST;
         block_height_ff <= BLOCK_HEIGHT_RST;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
            REG_SRC_WIDTH:    src_width_ff    <= csr_pwdata[SRC_DIM_W-1:0];
            REG_SRC_HEIGHT:   src_height_ff   <= csr_pwdata[SRC_DIM_W-1:0];
            REG_OUT_WIDTH:    out_width_ff    <= csr_pwdata[OUT_DIM_W-1:0];
            REG_OUT_HEIGHT:   out_height_ff   <= csr_pwdata[OUT_DIM_W-1:0];
            REG_BLOCK_WIDTH:  block_width_ff  <= csr_pwdata[BLK_DIM_W-1:0];
            REG_BLOCK_HEIGHT: block_height_ff <= csr_pwdata[BLK_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
         REG_SRC_WIDTH:    csr_prdata = CSR_DATA_W'(src_width_ff);
         REG_SRC_HEIGHT:   csr_prdata = CSR_DATA_W'(src_height_ff);
         REG_OUT_WIDTH:    csr_prdata = CSR_DATA_W'(out_width_ff);
         REG_OUT_HEIGHT:   csr_prdata = CSR_DATA_W'(out_height_ff);
         REG_BLOCK_WIDTH:  csr_prdata = CSR_DATA_W'(block_width_ff);
         REG_BLOCK_HEIGHT: csr_prdata = CSR_DATA_W'(block_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // limits clamped to their legal ranges
   always_comb begin
      if (src_width_ff == '0)                       sw_c = SWW'(1);
      else if (32'(src_width_ff) > MAX_SRC_WIDTH)   sw_c = SWW'(MAX_SRC_WIDTH);
      else                                          sw_c = SWW'(src_width_ff);

      if (src_height_ff == '0)                      sh_c = SRC_DIM_W'(1);
      else if (32'(src_height_ff) > SRC_HEIGHT_MAX) sh_c = SRC_DIM_W'(SRC_HEIGHT_MAX);
      else                                          sh_c = src_height_ff;

      if (out_width_ff == '0)                       ow_c = BCW'(1);
      else if (32'(out_width_ff) > MAX_OUT_WIDTH)   ow_c = BCW'(MAX_OUT_WIDTH);
      else                                          ow_c = BCW'(out_width_ff);

      if (out_height_ff == '0)                      oh_c = OUT_DIM_W'(1);
      else if (32'(out_height_ff) > OUT_HEIGHT_MAX) oh_c = OUT_DIM_W'(OUT_HEIGHT_MAX);
      else                                          oh_c = out_height_ff;

      if (block_width_ff == '0)                     bw_c = BKW'(1);
      else if (32'(block_width_ff) > MAX_BLOCK)     bw_c = BKW'(MAX_BLOCK);
      else                                          bw_c = BKW'(block_width_ff);

      if (block_height_ff == '0)                    bh_c = BKW'(1);
      else if (32'(block_height_ff) > MAX_BLOCK)    bh_c = BKW'(MAX_BLOCK);
      else                                          bh_c = BKW'(block_height_ff);
   end

   // pixel decode against the current position
   assign accept     = req_valid & req_ready;
   assign covered    = (32'(block_col_ff) < 32'(ow_c)) && (32'(block_row_ff) < 32'(oh_c));
   assign last_col   = (32'(col_in_block_ff) + 32'd1) >= 32'(bw_c);
   assign last_row   = (32'(row_in_block_ff) + 32'd1) >= 32'(bh_c);
   assign emit       = covered && last_col && last_row;
   assign frame_last = ((32'(block_col_ff) + 32'd1) == 32'(ow_c)) &&
                       ((32'(block_row_ff) + 32'd1) == 32'(oh_c));
   assign bc_ext     = 32'(block_col_ff);
   assign br_ext     = 32'(block_row_ff);

   // position advance
   always_comb begin
      src_col_in      = src_col_ff;
      src_row_in      = src_row_ff;
      col_in_block_in = col_in_block_ff;
      block_col_in    = block_col_ff;
      row_in_block_in = row_in_block_ff;
      block_row_in    = block_row_ff;
      restart         = 1'b0;
      if (accept) begin
         if (last_col) begin
            col_in_block_in = '0;
            if (32'(block_col_ff) < 32'(ow_c)) block_col_in = block_col_ff + BCW'(1);
         end else begin
            col_in_block_in = col_in_block_ff + CBW'(1);
         end
         if ((32'(src_col_ff) + 32'd1) >= 32'(sw_c)) begin
            src_col_in      = '0;
            col_in_block_in = '0;
            block_col_in    = '0;
            if (last_row) begin
               row_in_block_in = '0;
               if (32'(block_row_ff) < 32'(oh_c)) block_row_in = block_row_ff + BLOCK_ROW_W'(1);
            end else begin
               row_in_block_in = row_in_block_ff + CBW'(1);
            end
            if ((32'(src_row_ff) + 32'd1) >= 32'(sh_c)) begin
               src_row_in      = '0;
               row_in_block_in = '0;
               block_row_in    = '0;
               restart         = 1'b1;
            end else begin
               src_row_in = src_row_ff + SRC_ROW_W'(1);
            end
         end else begin
            src_col_in = src_col_ff + SCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff      <= '0;
         src_row_ff      <= '0;
         col_in_block_ff <= '0;
         block_col_ff    <= '0;
         row_in_block_ff <= '0;
         block_row_ff    <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         src_col_ff      <= src_col_in;
         src_row_ff      <= src_row_in;
         col_in_block_ff <= col_in_block_in;
         block_col_ff    <= block_col_in;
         row_in_block_ff <= row_in_block_in;
         block_row_ff    <= block_row_in;
         s1_valid_ff     <= accept;
      end
   end

   // stage register for the count update
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_black_ff   <= (req_red_value == '0);
         s1_first_ff   <= (row_in_block_ff == '0);
         s1_emit_ff    <= emit;
         s1_covered_ff <= covered;
         s1_restart_ff <= restart;
         s1_fdone_ff   <= frame_last;
         s1_bc_ff      <= block_col_ff;
         s1_x_ff       <= bc_ext[POS_W-1:0];
         s1_y_ff       <= br_ext[POS_W-1:0];
         s1_area_ff    <= CNTW'(bw_c) * CNTW'(bh_c);
      end
   end

   // count store read, registered, one row per cycle
   assign rd_row = ROW_W'(block_col_ff >> LANE_BITS);

   always_ff @(posedge clock) begin
      mem_rd_ff <= count_mem_ff[rd_row];
      if (wr_en) begin
         count_mem_ff[s1_row] <= wr_word;
      end
   end

   // last write kept for a read that raced it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_row_ff  <= s1_row;
         fwd_data_ff <= wr_word;
      end
   end

   // rows written since reset or frame start
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (s1_valid_ff && s1_restart_ff) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[s1_row] <= 1'b1;
      end
   end

   // count update and colour decision
   assign s1_row  = ROW_W'(s1_bc_ff >> LANE_BITS);
   assign s1_lane = LW'(s1_bc_ff & BCW'(LANES - 1));
   assign wr_en   = s1_valid_ff && s1_covered_ff;

   always_comb begin
      if (!row_valid_ff[s1_row])     row_word = '0;
      else if (fwd_row_ff == s1_row) row_word = fwd_data_ff;
      else                           row_word = mem_rd_ff;

      base_cnt = s1_first_ff ? '0 : row_word[s1_lane];
      cnt      = base_cnt + CNTW'(s1_black_ff);

      wr_word          = row_word;
      wr_word[s1_lane] = s1_emit_ff ? '0 : cnt;

      wht      = (s1_area_ff >= cnt) ? (s1_area_ff - cnt) : '0;
      is_black = (MW'(wht) * MW'(FRAC_DEN)) < (MW'(cnt) * MW'(FRAC_NUM));
   end

   // result queue
   assign push                 = s1_valid_ff && s1_emit_ff;
   assign pop                  = rsp_valid && rsp_ready;
   assign push_item.out_x      = s1_x_ff;
   assign push_item.out_y      = s1_y_ff;
   assign push_item.is_white   = ~is_black;
   assign push_item.frame_done = s1_fdone_ff;
   assign occupancy            = fifo_cnt_ff + FIFO_CNT_W'(push);
   assign req_ready            = (32'(occupancy) < FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   // result beat
   assign head           = fifo_ff[rd_ptr_ff];
   assign rsp_valid      = (fifo_cnt_ff != '0);
   assign rsp_out_x      = head.out_x;
   assign rsp_out_y      = head.out_y;
   assign rsp_is_white   = head.is_white;
   assign rsp_frame_done = head.frame_done;

endmodule

`default_nettype wire
